// ===== src/srb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

   localparam int DIM_W       = 9;
   localparam int ANGLE_W     = 9;
   localparam int ORIGIN_W    = 12;
   localparam int COORD_W     = 13;
   localparam int COLOR_W     = 8;
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 3;

   localparam logic [ANGLE_W-1:0] DEG_QUARTER       = 9'd90;
   localparam logic [ANGLE_W-1:0] DEG_HALF          = 9'd180;
   localparam logic [ANGLE_W-1:0] DEG_THREE_QUARTER = 9'd270;
   localparam logic [ANGLE_W-1:0] DEG_FULL          = 9'd360;

   localparam logic [DIM_W-1:0] DIM_RESET = 9'd16;

   localparam logic signed [COORD_W-1:0] COORD_MIN = -13'sd4096;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 13'sd4095;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPRITE_HEIGHT = 3'd0,
      CSR_SPRITE_WIDTH  = 3'd1,
      CSR_ANGLE_DEGREES = 3'd2,
      CSR_ORIGIN_X      = 3'd3,
      CSR_ORIGIN_Y      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

endpackage

`default_nettype wire

// ===== src/srb_trig.sv =====
`timescale 1ns / 1ps
`default_nettype none

module srb_trig #(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                             clock,
   input  logic [srb_pkg::ANGLE_W-1:0]      angle,
   output logic signed [TRIG_FRAC_BITS+1:0] sine,
   output logic signed [TRIG_FRAC_BITS+1:0] cosine
);
   import srb_pkg::*;

   localparam int TW         = TRIG_FRAC_BITS + 2;
   localparam int QW         = TRIG_FRAC_BITS + 1;
   localparam int QUAD_DEPTH = 91;
   localparam int QI_W       = $clog2(QUAD_DEPTH);
   localparam longint Q30_PI  = 64'sd3373259426;
   localparam longint Q30_ONE = 64'sd1073741824;

   typedef struct packed {
      logic            negate;
      logic [QI_W-1:0] index;
   } fold_type;

   function automatic longint taylor_step(input longint t, input longint x);
      longint p;
      p = (t * x) >>> 30;
      return (p * x) >>> 30;
   endfunction

   function automatic logic [QW-1:0] quad_value(input int deg);
      longint x;
      longint t;
      longint s;
      x = (longint'(deg) * Q30_PI + 64'sd90) / 64'sd180;
      t = x;
      s = x;
      t = taylor_step(t, x) / 64'sd6;
      s = s - t;
      t = taylor_step(t, x) / 64'sd20;
      s = s + t;
      t = taylor_step(t, x) / 64'sd42;
      s = s - t;
      t = taylor_step(t, x) / 64'sd72;
      s = s + t;
      t = taylor_step(t, x) / 64'sd110;
      s = s - t;
      t = taylor_step(t, x) / 64'sd156;
      s = s + t;
      t = taylor_step(t, x) / 64'sd210;
      s = s - t;
      if (s < 0) begin
         s = 0;
      end
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      s = (s + (64'sd1 <<< (29 - TRIG_FRAC_BITS))) >>> (30 - TRIG_FRAC_BITS);
      return s[QW-1:0];
   endfunction

   function automatic fold_type fold(input logic [ANGLE_W-1:0] k);
      fold_type f;
      if (k <= DEG_QUARTER) begin
         f.negate = 1'b0;
         f.index  = QI_W'(k);
      end else if (k <= DEG_HALF) begin
         f.negate = 1'b0;
         f.index  = QI_W'(DEG_HALF - k);
      end else if (k <= DEG_THREE_QUARTER) begin
         f.negate = 1'b1;
         f.index  = QI_W'(k - DEG_HALF);
      end else begin
         f.negate = 1'b1;
         f.index  = QI_W'(DEG_FULL - k);
      end
      return f;
   endfunction

   logic [QW-1:0] quad_rom [QUAD_DEPTH];

   for (genvar k = 0; k < QUAD_DEPTH; k++) begin : g_rom
      localparam logic [QW-1:0] QV = quad_value(k);
      assign quad_rom[k] = QV;
   end

   logic [ANGLE_W-1:0]   angle_mod;
   logic [ANGLE_W-1:0]   cos_raw;
   logic [ANGLE_W-1:0]   cos_angle;
   fold_type             sin_fold;
   fold_type             cos_fold;
   logic signed [TW-1:0] sin_mag;
   logic signed [TW-1:0] cos_mag;
   logic signed [TW-1:0] sine_in;
   logic signed [TW-1:0] cosine_in;
   logic signed [TW-1:0] sine_ff;
   logic signed [TW-1:0] cosine_ff;

   always_comb begin
      angle_mod = (angle >= DEG_FULL) ? angle - DEG_FULL : angle;
      cos_raw   = angle_mod + DEG_QUARTER;
      cos_angle = (cos_raw >= DEG_FULL) ? cos_raw - DEG_FULL : cos_raw;
      sin_fold  = fold(angle_mod);
      cos_fold  = fold(cos_angle);
      sin_mag   = $signed({1'b0, quad_rom[sin_fold.index]});
      cos_mag   = $signed({1'b0, quad_rom[cos_fold.index]});
      sine_in   = sin_fold.negate ? -sin_mag : sin_mag;
      cosine_in = cos_fold.negate ? -cos_mag : cos_mag;
   end

   always_ff @(posedge clock) begin
      sine_ff   <= sine_in;
      cosine_ff <= cosine_in;
   end

   assign sine   = sine_ff;
   assign cosine = cosine_ff;

endmodule

`default_nettype wire

// ===== src/sprite_rotation_blitter_unit.sv =====
// Rotating sprite blitter. Texels enter in row-major order, one word per
// accepted req handshake; row and column counters place each texel, which is
// rotated about the sprite center by angle_degrees and offset by the origin.
// Every texel yields four rsp words (ceil/ceil, floor/floor, ceil/floor,
// floor/ceil corners) carrying the texel color; last_of_run marks the fourth
// and sprite_done flags all four words of the final texel. The result port
// emits one word per cycle while rsp_stall is low; a new texel can be taken
// every cycle while the four-stage datapath (offset, multiply, sum,
// floor/ceil with origin add and saturation) has room. Words of a texel leave
// from the result register after the stage 1 to 4 registers. The user must
// write registers with csr_write while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module sprite_rotation_blitter_unit #(
   parameter int MAX_SPRITE_DIM = 256,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [srb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [srb_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [srb_pkg::COLOR_W-1:0]           req_texel_red,
   input  logic [srb_pkg::COLOR_W-1:0]           req_texel_green,
   input  logic [srb_pkg::COLOR_W-1:0]           req_texel_blue,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [srb_pkg::COORD_W-1:0]    rsp_screen_x,
   output logic signed [srb_pkg::COORD_W-1:0]    rsp_screen_y,
   output logic [srb_pkg::COLOR_W-1:0]           rsp_pixel_red,
   output logic [srb_pkg::COLOR_W-1:0]           rsp_pixel_green,
   output logic [srb_pkg::COLOR_W-1:0]           rsp_pixel_blue,
   output logic                                  rsp_last_of_run,
   output logic                                  rsp_sprite_done
);
   import srb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_SPRITE_DIM);
   localparam int DI_W   = ((CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W) + 1;
   localparam int TW     = TRIG_FRAC_BITS + 2;
   localparam int PW     = DI_W + TW;
   localparam int XN_W   = PW + 2;
   localparam int FL_W   = XN_W - TRIG_FRAC_BITS - 1;
   localparam int SUM_W  = ((FL_W > ORIGIN_W) ? FL_W : ORIGIN_W) + 2;

   typedef enum logic [1:0] {
      PH_CEIL_CEIL   = 2'd0,
      PH_FLOOR_FLOOR = 2'd1,
      PH_CEIL_FLOOR  = 2'd2,
      PH_FLOOR_CEIL  = 2'd3
   } phase_type;

   function automatic logic [DIM_W-1:0] effective_dim(input logic [DIM_W-1:0] d);
      if (d == '0) begin
         return DIM_W'(1);
      end else if (int'(d) > MAX_SPRITE_DIM) begin
         return DIM_W'(MAX_SPRITE_DIM);
      end
      return d;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
      if (v < SUM_W'(COORD_MIN)) begin
         return COORD_MIN;
      end else if (v > SUM_W'(COORD_MAX)) begin
         return COORD_MAX;
      end
      return COORD_W'(v);
   endfunction

   // configuration
   logic [DIM_W-1:0]           sprite_height_ff;
   logic [DIM_W-1:0]           sprite_width_ff;
   logic [ANGLE_W-1:0]         angle_degrees_ff;
   logic signed [ORIGIN_W-1:0] origin_x_ff;
   logic signed [ORIGIN_W-1:0] origin_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_height_ff <= DIM_RESET;
         sprite_width_ff  <= DIM_RESET;
         angle_degrees_ff <= '0;
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPRITE_HEIGHT: sprite_height_ff <= csr_data[DIM_W-1:0];
            CSR_SPRITE_WIDTH:  sprite_width_ff  <= csr_data[DIM_W-1:0];
            CSR_ANGLE_DEGREES: angle_degrees_ff <= csr_data[ANGLE_W-1:0];
            CSR_ORIGIN_X:      origin_x_ff      <= $signed(csr_data[ORIGIN_W-1:0]);
            CSR_ORIGIN_Y:      origin_y_ff      <= $signed(csr_data[ORIGIN_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   logic [DIM_W-1:0] h_eff;
   logic [DIM_W-1:0] w_eff;

   assign h_eff = effective_dim(sprite_height_ff);
   assign w_eff = effective_dim(sprite_width_ff);

   logic signed [TW-1:0] sine;
   logic signed [TW-1:0] cosine;

   srb_trig #(
      .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
   ) u_trig (
      .clock (clock),
      .angle (angle_degrees_ff),
      .sine  (sine),
      .cosine(cosine)
   );

   // flow control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s1_free, s2_free, s3_free, s4_free, out_free;
   logic s2_load, s3_load, s4_load, out_load;
   logic accept, rsp_fire;
   phase_type phase_ff;

   always_comb begin
      rsp_fire = out_valid_ff && !rsp_stall;
      out_free = !out_valid_ff || (rsp_fire && phase_ff == PH_FLOOR_CEIL);
      out_load = s4_valid_ff && out_free;
      s4_free  = !s4_valid_ff || out_load;
      s4_load  = s3_valid_ff && s4_free;
      s3_free  = !s3_valid_ff || s4_load;
      s3_load  = s2_valid_ff && s3_free;
      s2_free  = !s2_valid_ff || s3_load;
      s2_load  = s1_valid_ff && s2_free;
      s1_free  = !s1_valid_ff || s2_load;
      accept   = req_valid && s1_free;
   end

   assign req_stall = !s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // texel position counters
   logic [CNT_W-1:0] row_ff;
   logic [CNT_W-1:0] col_ff;
   logic             last_col;
   logic             last_row;

   assign last_col = DI_W'(col_ff) >= DI_W'(w_eff - DIM_W'(1));
   assign last_row = DI_W'(row_ff) >= DI_W'(h_eff - DIM_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_ff <= col_ff + CNT_W'(1);
         end
      end
   end

   // stage 1: centered offsets in half pixels
   color_type              s1_color_ff;
   logic                   s1_done_ff;
   logic signed [DI_W-1:0] s1_di_ff;
   logic signed [DI_W-1:0] s1_dj_ff;
   logic signed [DI_W-1:0] di_in;
   logic signed [DI_W-1:0] dj_in;

   assign di_in = $signed(DI_W'({row_ff, 1'b0})) - $signed(DI_W'(h_eff));
   assign dj_in = $signed(DI_W'({col_ff, 1'b0})) - $signed(DI_W'(w_eff));

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_color_ff <= '{red: req_texel_red, green: req_texel_green, blue: req_texel_blue};
         s1_done_ff  <= last_row && last_col;
         s1_di_ff    <= di_in;
         s1_dj_ff    <= dj_in;
      end
   end

   // stage 2: products
   color_type            s2_color_ff;
   logic                 s2_done_ff;
   logic signed [PW-1:0] s2_di_cos_ff;
   logic signed [PW-1:0] s2_dj_sin_ff;
   logic signed [PW-1:0] s2_di_sin_ff;
   logic signed [PW-1:0] s2_dj_cos_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_color_ff  <= s1_color_ff;
         s2_done_ff   <= s1_done_ff;
         s2_di_cos_ff <= PW'(s1_di_ff) * PW'(cosine);
         s2_dj_sin_ff <= PW'(s1_dj_ff) * PW'(sine);
         s2_di_sin_ff <= PW'(s1_di_ff) * PW'(sine);
         s2_dj_cos_ff <= PW'(s1_dj_ff) * PW'(cosine);
      end
   end

   // stage 3: rotated coordinates
   color_type              s3_color_ff;
   logic                   s3_done_ff;
   logic signed [XN_W-1:0] s3_xn_ff;
   logic signed [XN_W-1:0] s3_yn_ff;
   logic signed [XN_W-1:0] xn_in;
   logic signed [XN_W-1:0] yn_in;

   assign xn_in = XN_W'(s2_di_cos_ff) - XN_W'(s2_dj_sin_ff)
                  + $signed(XN_W'(h_eff) << TRIG_FRAC_BITS);
   assign yn_in = XN_W'(s2_di_sin_ff) + XN_W'(s2_dj_cos_ff)
                  + $signed(XN_W'(w_eff) << TRIG_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_color_ff <= s2_color_ff;
         s3_done_ff  <= s2_done_ff;
         s3_xn_ff    <= xn_in;
         s3_yn_ff    <= yn_in;
      end
   end

   // stage 4: floor, ceil, origin, saturate
   color_type                 s4_color_ff;
   logic                      s4_done_ff;
   logic signed [COORD_W-1:0] s4_xc_ff, s4_xf_ff, s4_yc_ff, s4_yf_ff;
   logic signed [FL_W-1:0]    x_floor, y_floor;
   logic                      x_frac, y_frac;
   logic signed [SUM_W-1:0]   xf_sum, xc_sum, yf_sum, yc_sum;

   always_comb begin
      x_floor = FL_W'(s3_xn_ff >>> (TRIG_FRAC_BITS + 1));
      y_floor = FL_W'(s3_yn_ff >>> (TRIG_FRAC_BITS + 1));
      x_frac  = |s3_xn_ff[TRIG_FRAC_BITS:0];
      y_frac  = |s3_yn_ff[TRIG_FRAC_BITS:0];
      xf_sum  = SUM_W'(x_floor) + SUM_W'(origin_x_ff);
      xc_sum  = SUM_W'(x_floor) + SUM_W'(origin_x_ff) + $signed(SUM_W'(x_frac));
      yf_sum  = SUM_W'(y_floor) + SUM_W'(origin_y_ff);
      yc_sum  = SUM_W'(y_floor) + SUM_W'(origin_y_ff) + $signed(SUM_W'(y_frac));
   end

   always_ff @(posedge clock) begin
      if (s4_load) begin
         s4_color_ff <= s3_color_ff;
         s4_done_ff  <= s3_done_ff;
         s4_xf_ff    <= clamp(xf_sum);
         s4_xc_ff    <= clamp(xc_sum);
         s4_yf_ff    <= clamp(yf_sum);
         s4_yc_ff    <= clamp(yc_sum);
      end
   end

   // result sequencer: four words per texel
   color_type                 out_color_ff;
   logic                      out_done_ff;
   logic signed [COORD_W-1:0] out_xc_ff, out_xf_ff, out_yc_ff, out_yf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_CEIL_CEIL;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
         phase_ff     <= PH_CEIL_CEIL;
      end else if (rsp_fire) begin
         out_valid_ff <= (phase_ff != PH_FLOOR_CEIL);
         phase_ff     <= phase_type'(phase_ff + 2'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_color_ff <= s4_color_ff;
         out_done_ff  <= s4_done_ff;
         out_xc_ff    <= s4_xc_ff;
         out_xf_ff    <= s4_xf_ff;
         out_yc_ff    <= s4_yc_ff;
         out_yf_ff    <= s4_yf_ff;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_CEIL_CEIL: begin
            rsp_screen_x = out_xc_ff;
            rsp_screen_y = out_yc_ff;
         end
         PH_FLOOR_FLOOR: begin
            rsp_screen_x = out_xf_ff;
            rsp_screen_y = out_yf_ff;
         end
         PH_CEIL_FLOOR: begin
            rsp_screen_x = out_xc_ff;
            rsp_screen_y = out_yf_ff;
         end
         default: begin
            rsp_screen_x = out_xf_ff;
            rsp_screen_y = out_yc_ff;
         end
      endcase
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_red   = out_color_ff.red;
   assign rsp_pixel_green = out_color_ff.green;
   assign rsp_pixel_blue  = out_color_ff.blue;
   assign rsp_last_of_run = (phase_ff == PH_FLOOR_CEIL);
   assign rsp_sprite_done = out_done_ff;

   logic [COORD_W:0] x_gap;
   logic [COORD_W:0] y_gap;

   assign x_gap = {out_xc_ff[COORD_W-1], out_xc_ff} - {out_xf_ff[COORD_W-1], out_xf_ff};
   assign y_gap = {out_yc_ff[COORD_W-1], out_yc_ff} - {out_yf_ff[COORD_W-1], out_yf_ff};

   a_corner_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (x_gap == '0 || x_gap == (COORD_W+1)'(1))
                 && (y_gap == '0 || y_gap == (COORD_W+1)'(1)))
      else $error("ceil and floor corners differ by more than one pixel");

   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(phase_ff))
      else $error("corner phase moved while the result was stalled");

   a_counter_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(row_ff) && $stable(col_ff))
      else $error("texel counters moved without an accepted word");

   a_done_run: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last_of_run |=> rsp_valid && $stable(rsp_sprite_done))
      else $error("sprite_done changed inside a run");

endmodule

`default_nettype wire
